/* rtl/aou_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and register codes of the Adam update block.
package aou_pkg;

  localparam int unsigned NUM_PARAMS_DEF = 4096;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 24;
  localparam int unsigned PC_W   = 13;

  localparam logic [15:0] BETA1_RST = 16'd58982;
  localparam logic [15:0] BETA2_RST = 16'd65470;
  localparam logic [23:0] LR_RST    = 24'd167772;
  localparam logic [7:0]  EPS_RST   = 8'd1;
  localparam logic [12:0] PC_RST    = 13'd4096;

  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;

  localparam int unsigned NUM_W  = 72;
  localparam int unsigned DEN_W  = 41;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = 42;
  localparam int unsigned CNT_W  = 7;
  localparam logic [6:0]  DIV_STEPS  = 7'd72;
  localparam logic [6:0]  SQRT_STEPS = 7'd32;

  typedef enum logic [2:0] {
    CFG_BETA1       = 3'd0,
    CFG_BETA2       = 3'd1,
    CFG_LEARN_RATE  = 3'd2,
    CFG_EPSILON     = 3'd3,
    CFG_PARAM_COUNT = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOM1,
    OP_MOM2,
    OP_SQG,
    OP_VMUL,
    OP_GMUL,
    OP_VSUM,
    OP_POW1,
    OP_POW2,
    OP_CAP_MHAT,
    OP_CAP_R,
    OP_CAP_S,
    OP_CAP_DEN,
    OP_PROD_LO,
    OP_PROD_HI,
    OP_CAP_STEP,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    U_NONE,
    U_MHAT,
    U_ROOTV,
    U_ROOTD,
    U_DEN,
    U_STEP
  } usel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_DIV1,
    ST_DIV1W,
    ST_SQ1,
    ST_SQ1W,
    ST_SQ2,
    ST_SQ2W,
    ST_DIV2,
    ST_DIV2W,
    ST_ML1,
    ST_ML2,
    ST_DIV3,
    ST_DIV3W,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e   op;
    logic  unit_start;
    usel_e usel;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/aou_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module aou_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/aou_divsqrt.sv */
`timescale 1ns / 1ps
// Shared restoring divider and integer square root, one result bit per cycle.
module aou_divsqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         sqrt_i,
  input  logic [aou_pkg::NUM_W-1:0]    num_i,
  input  logic [aou_pkg::DEN_W-1:0]    den_i,
  output logic                         done_o,
  output logic [aou_pkg::NUM_W-1:0]    quo_o,
  output logic [aou_pkg::ROOT_W-1:0]   root_o
);
  import aou_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sqrt_q, sqrt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  sh_q, sh_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  sub_b;
  logic [REM_W:0]    diff;
  logic              ge;

  always_comb begin
    rem_sh = sqrt_q ? {rem_q[REM_W-3:0], sh_q[63:62]} : {rem_q[REM_W-2:0], sh_q[NUM_W-1]};
    sub_b  = sqrt_q ? {8'd0, root_q, 2'b01} : {1'b0, den_q};
    diff   = {1'b0, rem_sh} - {1'b0, sub_b};
    ge     = !diff[REM_W];

    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    root_d = root_q;
    den_d  = den_q;

    if (start_i) begin
      busy_d = 1'b1;
      sqrt_d = sqrt_i;
      cnt_d  = sqrt_i ? SQRT_STEPS : DIV_STEPS;
      rem_d  = '0;
      sh_d   = sqrt_i ? {8'd0, num_i[63:0]} : num_i;
      root_d = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_W-1:0] : rem_sh;
      if (sqrt_q) begin
        sh_d   = {sh_q[NUM_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], ge};
      end else begin
        sh_d = {sh_q[NUM_W-2:0], ge};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sqrt_q <= sqrt_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    root_q <= root_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
  assign root_o = root_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("unit started while busy");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("done without a finished run");

  a_busy_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("busy with empty step count");

endmodule

/* rtl/aou_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer that steps the datapath through one Adam element update.
module aou_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  aou_pkg::status_t status_i,
  output aou_pkg::cmd_t    cmd_o
);
  import aou_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.op         = OP_NONE;
    cmd_o.unit_start = 1'b0;
    cmd_o.usel       = U_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_M1;
        end
      end
      ST_M1: begin
        cmd_o.op = OP_MOM1;
        state_d  = ST_M2;
      end
      ST_M2: begin
        cmd_o.op = OP_MOM2;
        state_d  = ST_M3;
      end
      ST_M3: begin
        cmd_o.op = OP_SQG;
        state_d  = ST_M4;
      end
      ST_M4: begin
        cmd_o.op = OP_VMUL;
        state_d  = ST_M5;
      end
      ST_M5: begin
        cmd_o.op = OP_GMUL;
        state_d  = ST_M6;
      end
      ST_M6: begin
        cmd_o.op = OP_VSUM;
        state_d  = ST_M7;
      end
      ST_M7: begin
        cmd_o.op = OP_POW1;
        state_d  = ST_M8;
      end
      ST_M8: begin
        cmd_o.op = OP_POW2;
        state_d  = ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.usel       = U_MHAT;
        cmd_o.unit_start = 1'b1;
        state_d          = ST_DIV1W;
      end
      ST_DIV1W: begin
        cmd_o.usel = U_MHAT;
        if (status_i.unit_done) begin
          cmd_o.op = OP_CAP_MHAT;
          state_d  = ST_SQ1;
        end
      end
      ST_SQ1: begin
        cmd_o.usel       = U_ROOTV;
        cmd_o.unit_start = 1'b1;
        state_d          = ST_SQ1W;
      end
      ST_SQ1W: begin
        cmd_o.usel = U_ROOTV;
        if (status_i.unit_done) begin
          cmd_o.op = OP_CAP_R;
          state_d  = ST_SQ2;
        end
      end
      ST_SQ2: begin
        cmd_o.usel       = U_ROOTD;
        cmd_o.unit_start = 1'b1;
        state_d          = ST_SQ2W;
      end
      ST_SQ2W: begin
        cmd_o.usel = U_ROOTD;
        if (status_i.unit_done) begin
          cmd_o.op = OP_CAP_S;
          state_d  = ST_DIV2;
        end
      end
      ST_DIV2: begin
        cmd_o.usel       = U_DEN;
        cmd_o.unit_start = 1'b1;
        state_d          = ST_DIV2W;
      end
      ST_DIV2W: begin
        cmd_o.usel = U_DEN;
        if (status_i.unit_done) begin
          cmd_o.op = OP_CAP_DEN;
          state_d  = ST_ML1;
        end
      end
      ST_ML1: begin
        cmd_o.op = OP_PROD_LO;
        state_d  = ST_ML2;
      end
      ST_ML2: begin
        cmd_o.op = OP_PROD_HI;
        state_d  = ST_DIV3;
      end
      ST_DIV3: begin
        cmd_o.usel       = U_STEP;
        cmd_o.unit_start = 1'b1;
        state_d          = ST_DIV3W;
      end
      ST_DIV3W: begin
        cmd_o.usel = U_STEP;
        if (status_i.unit_done) begin
          cmd_o.op = OP_CAP_STEP;
          state_d  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/aou_dp.sv */
`timescale 1ns / 1ps
// Datapath: registers, moment stores, arithmetic and output register.
module aou_dp #(
  parameter int unsigned NUM_PARAMS = aou_pkg::NUM_PARAMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [aou_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [aou_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic signed [31:0]          current_value_i,
  input  logic signed [31:0]          gradient_i,
  input  aou_pkg::cmd_t               cmd_i,
  output aou_pkg::status_t            status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          updated_value_o,
  output logic                        pass_done_o
);
  import aou_pkg::*;

  localparam int unsigned IW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam int unsigned CW = (IW + 1 > PC_W) ? IW + 1 : PC_W;

  logic [15:0] beta1_q, beta2_q;
  logic [23:0] lr_q;
  logic [7:0]  eps_q;
  logic [12:0] pc_q;
  logic [32:0] bp1_q, bp2_q;
  logic [IW-1:0] idx_q;
  logic [IW:0]   fill_q;
  logic          out_valid_q;
  logic signed [31:0] updated_q;
  logic          pass_done_q;

  logic signed [31:0] cur_q, g_q, m_q;
  logic          last_q;
  logic signed [49:0] t0_q;
  logic [31:0] gmag_q;
  logic [63:0] g2_q, vh_q, v_q;
  logic [31:0] vl_q;
  logic [64:0] gh_q;
  logic [32:0] gl_q;
  logic [32:0] p1_q, p2_q;
  logic [47:0] mhat_q;
  logic [31:0] r_q, s_q;
  logic [40:0] den_q;
  logic [47:0] plo_q;
  logic [71:0] prod_q;
  logic [33:0] step_q;

  logic               rd_valid;
  logic [31:0]        fm_rdata;
  logic [63:0]        vm_rdata;
  logic signed [31:0] m_old;
  logic [63:0]        v_old;
  logic [16:0]        omb1, omb2;
  logic signed [49:0] t1;
  logic signed [50:0] msum;
  logic signed [34:0] m_sh;
  logic signed [31:0] m_d;
  logic [31:0]        gmag_d, mmag;
  logic [65:0]        vsum;
  logic [63:0]        v_d;
  logic [33:0]        vlo;
  logic [48:0]        p1_full, p2_full;
  logic [32:0]        d1, d2;
  logic [CW-1:0]      cnt, pc_ext;
  logic               last_d;
  logic               unit_sqrt;
  logic [NUM_W-1:0]   unit_num, quo;
  logic [DEN_W-1:0]   unit_den;
  logic [ROOT_W-1:0]  root;
  logic               unit_done;
  logic [40:0]        den_d;
  logic [33:0]        step_d;
  logic [35:0]        res;
  logic signed [31:0] res_sat;
  logic [47:0]        phi;

  assign rd_valid = {1'b0, idx_q} < fill_q;
  assign m_old    = rd_valid ? $signed(fm_rdata) : 32'sd0;
  assign v_old    = rd_valid ? vm_rdata : 64'd0;

  always_comb begin
    omb1   = 17'(18'd65536 - {2'b00, beta1_q});
    omb2   = 17'(18'd65536 - {2'b00, beta2_q});
    t1     = $signed({1'b0, omb1}) * g_q;
    msum   = 51'(t0_q) + 51'(t1);
    m_sh   = $signed(msum[50:16]);
    if (m_sh[34:31] != {4{m_sh[34]}}) begin
      m_d = m_sh[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      m_d = m_sh[31:0];
    end
    gmag_d = g_q[31] ? 32'd0 - g_q : g_q;
    mmag   = m_q[31] ? 32'd0 - m_q : m_q;
    vlo    = 34'(vl_q) + 34'(gl_q);
    vsum   = 66'(vh_q) + 66'(gh_q) + 66'(vlo[33:16]);
    v_d    = vsum[63:0];
    p1_full = bp1_q * beta1_q;
    p2_full = bp2_q * beta2_q;
    d1     = ONE_Q32 - p1_q;
    d2     = ONE_Q32 - p2_q;
    pc_ext = CW'(pc_q);
    if (pc_q == '0) begin
      cnt = CW'(1);
    end else if (pc_ext > CW'(NUM_PARAMS)) begin
      cnt = CW'(NUM_PARAMS);
    end else begin
      cnt = pc_ext;
    end
    last_d = (CW'(idx_q) + CW'(1)) >= cnt;
    den_d  = {1'b0, quo[39:0]} + 41'(eps_q);
    if (den_d == '0) begin
      den_d = 41'd1;
    end
    if ((|quo[71:34]) || (quo[33] && (|quo[32:0]))) begin
      step_d = STEP_CAP;
    end else begin
      step_d = quo[33:0];
    end
    phi = lr_q * mhat_q[47:24];
    res = m_q[31] ? {{4{cur_q[31]}}, cur_q} + {2'b00, step_q}
                  : {{4{cur_q[31]}}, cur_q} - {2'b00, step_q};
    if (res[35:31] != {5{res[35]}}) begin
      res_sat = res[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res_sat = res[31:0];
    end
  end

  always_comb begin
    unit_sqrt = 1'b0;
    unit_num  = '0;
    unit_den  = '0;
    case (cmd_i.usel)
      U_MHAT: begin
        unit_num = {8'd0, mmag, 32'd0};
        unit_den = {8'd0, d1};
      end
      U_ROOTV: begin
        unit_sqrt = 1'b1;
        unit_num  = {8'd0, v_q};
      end
      U_ROOTD: begin
        unit_sqrt = 1'b1;
        unit_num  = {9'd0, d2, 30'd0};
      end
      U_DEN: begin
        unit_num = {9'd0, r_q, 31'd0};
        unit_den = {9'd0, s_q};
      end
      U_STEP: begin
        unit_num = prod_q;
        unit_den = den_q;
      end
      default: begin
        unit_sqrt = 1'b0;
      end
    endcase
  end

  aou_divsqrt u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.unit_start),
    .sqrt_i  (unit_sqrt),
    .num_i   (unit_num),
    .den_i   (unit_den),
    .done_o  (unit_done),
    .quo_o   (quo),
    .root_o  (root)
  );

  aou_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS), .AW(IW)) u_first_moment (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_MOM2),
    .waddr_i (idx_q),
    .wdata_i (m_d),
    .raddr_i (idx_q),
    .rdata_o (fm_rdata)
  );

  aou_ram #(.WIDTH(64), .DEPTH(NUM_PARAMS), .AW(IW)) u_second_moment (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_VSUM),
    .waddr_i (idx_q),
    .wdata_i (v_d),
    .raddr_i (idx_q),
    .rdata_o (vm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta1_q     <= BETA1_RST;
      beta2_q     <= BETA2_RST;
      lr_q        <= LR_RST;
      eps_q       <= EPS_RST;
      pc_q        <= PC_RST;
      bp1_q       <= ONE_Q32;
      bp2_q       <= ONE_Q32;
      idx_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BETA1:       beta1_q <= cfg_wdata_i[15:0];
          CFG_BETA2:       beta2_q <= cfg_wdata_i[15:0];
          CFG_LEARN_RATE:  lr_q    <= cfg_wdata_i;
          CFG_EPSILON:     eps_q   <= cfg_wdata_i[7:0];
          CFG_PARAM_COUNT: pc_q    <= cfg_wdata_i[12:0];
          default:         ;
        endcase
      end
      if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
        if ({1'b0, idx_q} == fill_q) begin
          fill_q <= fill_q + (IW+1)'(1);
        end
        if (last_q) begin
          bp1_q <= p1_q;
          bp2_q <= p2_q;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + IW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cur_q  <= current_value_i;
        g_q    <= gradient_i;
        last_q <= last_d;
      end
      OP_MOM1:     t0_q   <= $signed({2'b00, beta1_q}) * m_old;
      OP_MOM2: begin
        m_q    <= m_d;
        gmag_q <= gmag_d;
      end
      OP_SQG:      g2_q   <= gmag_q * gmag_q;
      OP_VMUL: begin
        vh_q <= v_old[63:16] * beta2_q;
        vl_q <= v_old[15:0] * beta2_q;
      end
      OP_GMUL: begin
        gh_q <= g2_q[63:16] * omb2;
        gl_q <= g2_q[15:0] * omb2;
      end
      OP_VSUM:     v_q    <= v_d;
      OP_POW1:     p1_q   <= p1_full[48:16];
      OP_POW2:     p2_q   <= p2_full[48:16];
      OP_CAP_MHAT: mhat_q <= quo[47:0];
      OP_CAP_R:    r_q    <= root;
      OP_CAP_S:    s_q    <= root;
      OP_CAP_DEN:  den_q  <= den_d;
      OP_PROD_LO:  plo_q  <= lr_q * mhat_q[23:0];
      OP_PROD_HI:  prod_q <= 72'(plo_q) + {phi, 24'd0};
      OP_CAP_STEP: step_q <= step_d;
      OP_FINISH: begin
        updated_q   <= res_sat;
        pass_done_q <= last_q;
      end
      default: ;
    endcase
  end

  assign status_o.unit_done = unit_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign updated_value_o    = updated_q;
  assign pass_done_o        = pass_done_q;

endmodule

/* rtl/adam_optimizer_update.sv */
`timescale 1ns / 1ps
// Top level of the Adam optimizer update block.
// Each accepted (current_value, gradient) pair yields one updated value, and a new
// pair is taken the cycle after a result is loaded into the output register, so one
// element is finished before the next is accepted. The time per element is set by the
// shared restoring divide and square-root unit, one quotient or root bit per cycle:
// three 72-step divisions and two 32-step roots per element. Moment stores start
// empty through a fill count, so there is no clearing pass after reset.
module adam_optimizer_update #(
  parameter int unsigned NUM_PARAMS = aou_pkg::NUM_PARAMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [aou_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [aou_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          current_value_i,
  input  logic signed [31:0]          gradient_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          updated_value_o,
  output logic                        pass_done_o
);
  import aou_pkg::*;

  cmd_t    cmd;
  status_t status;

  aou_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aou_dp #(.NUM_PARAMS(NUM_PARAMS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .current_value_i (current_value_i),
    .gradient_i      (gradient_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .updated_value_o (updated_value_o),
    .pass_done_o     (pass_done_o)
  );

endmodule

/* bench/tb_adam_optimizer_update.sv */
`timescale 1ns / 1ps
// Self-checking testbench: directed table plus randomised passes of the Adam update block.
module tb_adam_optimizer_update;
  import aou_pkg::*;

  localparam int unsigned NPAR         = 4096;
  localparam int unsigned WATCHDOG_LIM = 4000;
  localparam int unsigned RAND_ITEMS   = 1400;
  localparam logic [2:0]  CFG_UNMAPPED = 3'd5;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [2:0]         addr;
    logic [23:0]        data;
    logic signed [31:0] cv;
    logic signed [31:0] grad;
    bit                 typed;
    logic signed [31:0] exp_val;
    bit                 exp_done;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] val;
    bit                 done;
  } update_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]           cfg_addr_i = '0;
  logic [CFG_DW-1:0]           cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [31:0]          current_value_i = '0;
  logic signed [31:0]          gradient_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [31:0]          updated_value_o;
  logic                        pass_done_o;

  adam_optimizer_update DUT (.*);

  always #1 clk_i = ~clk_i;

  // model state
  logic [15:0]        beta1_q, beta2_q;
  logic [23:0]        lr_q;
  logic [7:0]         eps_q;
  logic [12:0]        count_q;
  logic signed [31:0] mom1_mem [NPAR];
  logic [63:0]        mom2_mem [NPAR];
  logic [63:0]        pow1_q, pow2_q;
  int unsigned        elem_q;

  update_t     pending_q[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned rx_wait = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic update_t adam_step(logic signed [31:0] cv, logic signed [31:0] g);
    update_t     r;
    int unsigned cnt, idx;
    bit          last;
    longint      m, res;
    logic [63:0] p1, p2, d1, d2, w1, w2, gmag, g2, v, mmag, mhat, root_v, root_d, den, step;
    logic [127:0] quot;
    cnt = (count_q == 0) ? 1 : count_q;
    if (cnt > NPAR) cnt = NPAR;
    idx = (elem_q >= NPAR) ? 0 : elem_q;
    last = (idx + 1 >= cnt);
    p1 = (pow1_q * beta1_q) >> 16;
    p2 = (pow2_q * beta2_q) >> 16;
    w1 = 64'd65536 - beta1_q;
    w2 = 64'd65536 - beta2_q;
    m = (longint'(beta1_q) * longint'(mom1_mem[idx]) + longint'(w1) * longint'(g)) >>> 16;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    mom1_mem[idx] = m[31:0];
    gmag = (g < 0) ? -longint'(g) : longint'(g);
    g2 = gmag * gmag;
    v = mom2_mem[idx];
    v = (v >> 16) * beta2_q + (g2 >> 16) * w2 +
        (((v & 64'hFFFF) * beta2_q + (g2 & 64'hFFFF) * w2) >> 16);
    mom2_mem[idx] = v;
    d1 = 64'd1 << 32;
    d1 = d1 - p1;
    d2 = (64'd1 << 32) - p2;
    mmag = (m < 0) ? -m : m;
    mhat = (mmag << 32) / d1;
    root_v = int_sqrt(v);
    root_d = int_sqrt(d2 << 30);
    den = (root_v << 31) / root_d + eps_q;
    if (den == 0) den = 1;
    quot = (128'(lr_q) * 128'(mhat)) / 128'(den);
    step = (quot > 128'(STEP_CAP)) ? 64'(STEP_CAP) : quot[63:0];
    res = (m < 0) ? longint'(cv) + longint'(step) : longint'(cv) - longint'(step);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    if (last) begin
      pow1_q = p1;
      pow2_q = p2;
      elem_q = 0;
    end else begin
      elem_q = idx + 1;
    end
    r.val = res[31:0];
    r.done = last;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [23:0] data);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = data;
    case (addr)
      CFG_BETA1:       beta1_q = data[15:0];
      CFG_BETA2:       beta2_q = data[15:0];
      CFG_LEARN_RATE:  lr_q = data;
      CFG_EPSILON:     eps_q = data[7:0];
      CFG_PARAM_COUNT: count_q = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_item(logic signed [31:0] cv, logic signed [31:0] g, bit typed,
                           logic signed [31:0] ev, bit ed);
    int unsigned gap;
    update_t     u;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    current_value_i = cv;
    gradient_i = g;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    u = adam_step(cv, g);
    if (typed) begin
      u.val = ev;
      u.done = ed;
    end
    pending_q.push_back(u);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_q824();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3:       return 32'sd0;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [23:0] pick(logic [23:0] hi, logic [23:0] dflt);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return hi;
      2:       return dflt;
      default: return 24'($urandom_range(0, hi));
    endcase
  endfunction

  // on the DUT side
  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", updated_value_o, 0);
      end else begin
        if (updated_value_o !== pending_q[0].val)
          report("updated_value", updated_value_o, pending_q[0].val);
        if (pass_done_o !== pending_q[0].done)
          report("pass_done", pass_done_o, pending_q[0].done);
        void'(pending_q.pop_front());
      end
      rx_wait = stalls_on ? $urandom_range(0, 14) : 0;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = rst_ni && (rx_wait == 0);
    if (rx_wait > 0) rx_wait--;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIM) begin
      $display("adam_optimizer_update regression: fail");
      $finish;
    end
  end

  stim_row_t directed_tbl[] = '{
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh0000_0000, 32'sh0000_0000, 1, 32'sh0000_0000, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh7FFF_FFFF, 32'sh0000_0000, 1, 32'sh7FFF_FFFF, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh8000_0000, 32'sh0000_0000, 1, 32'sh8000_0000, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh0100_0000, 32'sh7FFF_FFFF, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh0000_0000, 32'sh8000_0000, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh1234_5678, 32'sh0000_0001, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, -32'sd1,        -32'sd1,        0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh0000_0000, 32'sh0080_0000, 0, 32'sh0, 0},
    '{ROW_CFG,  CFG_EPSILON, 24'd0, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sd5,         32'sh0000_0000, 1, 32'sd5, 0},
    '{ROW_ITEM, 3'd0, 24'd0, -32'sd5,        32'sh0000_0000, 1, -32'sd5, 0},
    '{ROW_CFG,  CFG_PARAM_COUNT, 24'd5, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sd9,         32'sh0000_0000, 1, 32'sd9, 1},
    '{ROW_CFG,  CFG_PARAM_COUNT, 24'd0, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sd3,         32'sh0000_0000, 1, 32'sd3, 1},
    '{ROW_CFG,  CFG_PARAM_COUNT, 24'd5000, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh0200_0000, 32'sh0100_0000, 0, 32'sh0, 0},
    '{ROW_CFG,  CFG_UNMAPPED, 24'hFFFFFF, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh0200_0000, -32'sh0100_0000, 0, 32'sh0, 0},
    '{ROW_CFG,  CFG_LEARN_RATE, 24'd0, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sd77,        32'sh0100_0000, 1, 32'sd77, 0},
    '{ROW_CFG,  CFG_LEARN_RATE, 24'hFFFFFF, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_CFG,  CFG_BETA1, 24'd0, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_CFG,  CFG_BETA2, 24'd0, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_CFG,  CFG_EPSILON, 24'd255, 32'sh0, 32'sh0, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh0000_1000, 32'sh7FFF_FFFF, 0, 32'sh0, 0},
    '{ROW_ITEM, 3'd0, 24'd0, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh0, 0}
  };

  initial begin
    int unsigned sent, burst;
    beta1_q = BETA1_RST;
    beta2_q = BETA2_RST;
    lr_q = LR_RST;
    eps_q = EPS_RST;
    count_q = PC_RST;
    foreach (mom1_mem[i]) begin
      mom1_mem[i] = '0;
      mom2_mem[i] = '0;
    end
    pow1_q = 64'd1 << 32;
    pow2_q = 64'd1 << 32;
    elem_q = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].kind == ROW_CFG) begin
        in_valid_i = 1'b0;
        write_reg(directed_tbl[i].addr, directed_tbl[i].data);
      end else begin
        send_item(directed_tbl[i].cv, directed_tbl[i].grad, directed_tbl[i].typed,
                  directed_tbl[i].exp_val, directed_tbl[i].exp_done);
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      in_valid_i = 1'b0;
      write_reg(CFG_BETA1, pick(24'hFFFF, 24'(BETA1_RST)));
      write_reg(CFG_BETA2, pick(24'hFFFF, 24'(BETA2_RST)));
      write_reg(CFG_LEARN_RATE, pick(24'hFFFFFF, LR_RST));
      write_reg(CFG_EPSILON, pick(24'hFF, 24'(EPS_RST)));
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_PARAM_COUNT, 24'd0);
        1:       write_reg(CFG_PARAM_COUNT, 24'h1FFF);
        2:       write_reg(CFG_PARAM_COUNT, 24'($urandom_range(9, 64)));
        default: write_reg(CFG_PARAM_COUNT, 24'($urandom_range(1, 8)));
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(5, 7)), 24'($urandom));
      gaps_on = ($urandom_range(0, 2) != 0);
      stalls_on = ($urandom_range(0, 2) != 0);
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        send_item(rand_q824(), rand_q824(), 1'b0, 32'sh0, 1'b0);
        sent++;
      end
    end
    in_valid_i = 1'b0;
    wait_idle();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0)
      $display("adam_optimizer_update regression: pass");
    else
      $display("adam_optimizer_update regression: fail");
    $finish;
  end

endmodule
